### hdl/lcs_pkg.sv
// ============================================================================
// Line command sanitizer package
// Character constants, the key filter and the line-end result bundle shared
// by the line tracker and the top level.
// ============================================================================
`default_nettype none

package lcs_pkg;

    // Character codes used by the matcher and the result builder.
    localparam logic [7:0] CHR_LF       = 8'h0A;
    localparam logic [7:0] CHR_CR       = 8'h0D;
    localparam logic [7:0] CHR_SPACE    = 8'h20;
    localparam logic [7:0] CHR_TILDE    = 8'h7E;
    localparam logic [7:0] CHR_ZERO     = 8'h30;
    localparam logic [7:0] CHR_NINE     = 8'h39;
    localparam logic [7:0] CHR_A        = 8'h41;
    localparam logic [7:0] CHR_P        = 8'h50;
    localparam logic [7:0] CHR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Number of bytes sent for a full command and for a single key.
    localparam int          CMD_BYTES   = 8;
    localparam logic [3:0]  LEN_NONE    = 4'd0;
    localparam logic [3:0]  LEN_KEY     = 4'd1;
    localparam logic [3:0]  LEN_CMD     = 4'd8;

    // What a line end hands to the output stage: length and bytes, first byte
    // in the lowest bits.
    typedef struct packed {
        logic [3:0]               len;
        logic [CMD_BYTES*8-1:0]   bytes;
    } emit_t;

    // True for the characters that may stand alone as a key command.
    function automatic logic key_allowed(input logic [7:0] c);
        logic ok;
        begin
            unique case (c)
                8'h46, 8'h42, 8'h4C, 8'h52,     // F B L R
                8'h57, 8'h58, 8'h59, 8'h5A,     // W X Y Z
                8'h55, 8'h53, 8'h44: begin      // U S D
                    ok = 1'b1;
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
            return ok;
        end
    endfunction

    // Map a stored digit value back to its ASCII code.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return {4'h3, d};
    endfunction

endpackage

`default_nettype wire

### hdl/lcs_line_tracker.sv
// ============================================================================
// Line tracker
// Holds the per-line match state, updates it for each byte that is stepped
// in, and presents the result that a line end would produce.
// ============================================================================
`default_nettype none

module lcs_line_tracker (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,       // consume rx_byte this cycle
    input  wire logic [7:0]    rx_byte,
    output logic               line_end,   // rx_byte is LF or CR
    output lcs_pkg::emit_t     emit        // result if rx_byte ends the line
);
    import lcs_pkg::*;

    typedef enum logic [2:0] {
        PH_SEEK_A,
        PH_ANGLE,
        PH_SEEK_P,
        PH_POWER,
        PH_DONE
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [1:0]   digit_count_reg, digit_count_next;
    logic [3:0]   angle_reg [3];
    logic [3:0]   angle_next [3];
    logic [3:0]   power_reg [2];
    logic [3:0]   power_next [2];
    logic [1:0]   visible_count_reg, visible_count_next;
    logic [7:0]   first_visible_reg, first_visible_next;

    logic [7:0]   clean_byte;
    logic         is_digit;
    logic [3:0]   digit_val;

    // Sanitize: unprintable bytes become spaces, lower case becomes upper case.
    always_comb begin
        if (rx_byte < CHR_SPACE || rx_byte > CHR_TILDE) begin
            clean_byte = CHR_SPACE;
        end else if (rx_byte >= CHR_LOWER_A && rx_byte <= CHR_LOWER_Z) begin
            clean_byte = rx_byte - CASE_OFFSET;
        end else begin
            clean_byte = rx_byte;
        end
    end

    assign line_end  = (rx_byte == CHR_LF) || (rx_byte == CHR_CR);
    assign is_digit  = (clean_byte >= CHR_ZERO) && (clean_byte <= CHR_NINE);
    assign digit_val = clean_byte[3:0];

    // Result for a line end, taken from the state before this byte.
    always_comb begin
        emit.len   = LEN_NONE;
        emit.bytes = '0;
        if (phase_reg == PH_DONE) begin
            emit.len   = LEN_CMD;
            emit.bytes = {CHR_LF,
                          digit_char(power_reg[1]), digit_char(power_reg[0]),
                          CHR_P,
                          digit_char(angle_reg[2]), digit_char(angle_reg[1]),
                          digit_char(angle_reg[0]),
                          CHR_A};
        end else if (visible_count_reg == 2'd1 && key_allowed(first_visible_reg)) begin
            emit.len        = LEN_KEY;
            emit.bytes[7:0] = first_visible_reg;
        end
    end

    // Next line state for one byte.
    always_comb begin
        phase_next         = phase_reg;
        digit_count_next   = digit_count_reg;
        angle_next         = angle_reg;
        power_next         = power_reg;
        visible_count_next = visible_count_reg;
        first_visible_next = first_visible_reg;

        if (line_end) begin
            phase_next         = PH_SEEK_A;
            digit_count_next   = 2'd0;
            angle_next         = '{default: 4'd0};
            power_next         = '{default: 4'd0};
            visible_count_next = 2'd0;
            first_visible_next = 8'd0;
        end else begin
            // Count non-space characters, saturating at two.
            if (clean_byte != CHR_SPACE) begin
                if (visible_count_reg == 2'd0) begin
                    first_visible_next = clean_byte;
                end
                if (visible_count_reg != 2'd2) begin
                    visible_count_next = visible_count_reg + 2'd1;
                end
            end

            // Pattern matcher: A, three digits, P, two digits.
            unique case (phase_reg)
                PH_SEEK_A: begin
                    if (clean_byte == CHR_A) begin
                        phase_next       = PH_ANGLE;
                        digit_count_next = 2'd0;
                    end
                end
                PH_ANGLE: begin
                    if (is_digit) begin
                        angle_next[digit_count_reg] = digit_val;
                        if (digit_count_reg == 2'd2) begin
                            phase_next       = PH_SEEK_P;
                            digit_count_next = 2'd0;
                        end else begin
                            digit_count_next = digit_count_reg + 2'd1;
                        end
                    end
                end
                PH_SEEK_P: begin
                    if (clean_byte == CHR_P) begin
                        phase_next       = PH_POWER;
                        digit_count_next = 2'd0;
                    end
                end
                PH_POWER: begin
                    if (is_digit) begin
                        power_next[digit_count_reg[0]] = digit_val;
                        if (digit_count_reg[0]) begin
                            phase_next       = PH_DONE;
                            digit_count_next = 2'd0;
                        end else begin
                            digit_count_next = 2'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Line state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_SEEK_A;
            digit_count_reg   <= 2'd0;
            angle_reg         <= '{default: 4'd0};
            power_reg         <= '{default: 4'd0};
            visible_count_reg <= 2'd0;
            first_visible_reg <= 8'd0;
        end else if (step) begin
            phase_reg         <= phase_next;
            digit_count_reg   <= digit_count_next;
            angle_reg         <= angle_next;
            power_reg         <= power_next;
            visible_count_reg <= visible_count_next;
            first_visible_reg <= first_visible_next;
        end
    end

endmodule

`default_nettype wire

### hdl/line_command_sanitizer_unit.sv
// ============================================================================
// Line command sanitizer unit
// Turns a received byte stream into cleaned line commands.
// ============================================================================
// Bytes enter through an input register, one per cycle while s_tready is
// high. A byte that does not end a line is absorbed as soon as it reaches
// the input register and never waits on the output side. A line end (LF or
// CR) loads an output burst register with the line's result: the seven bytes
// "A ddd P dd" plus LF after a full match, or one key byte, or nothing. The
// burst then drains at one byte per cycle while m_tready is high, and m_tlast
// marks its final byte. A second line end that arrives while a burst is still
// draining waits in the input register until the burst's last byte is taken,
// and holds the bytes behind it; all other bytes run at one per cycle.
`default_nettype none

module line_command_sanitizer_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // Input requests.
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,    // [7:0] rx_byte
    // Result requests.
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,    // [7:0] out_byte
    output logic               m_tlast     // last_of_run
);
    import lcs_pkg::*;

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic [3:0]              burst_count_reg, burst_count_next;
    logic [CMD_BYTES*8-1:0]  burst_data_reg, burst_data_next;

    logic    line_end;
    emit_t   emit;
    logic    burst_free;
    logic    advance;
    logic    out_take;

    lcs_line_tracker u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .rx_byte  (in_byte_reg),
        .line_end (line_end),
        .emit     (emit)
    );

    // Handshake control.
    assign out_take   = m_tvalid && m_tready;
    assign burst_free = (burst_count_reg == LEN_NONE) ||
                        (burst_count_reg == LEN_KEY && out_take);
    assign advance    = in_valid_reg && (!line_end || burst_free);
    assign s_tready   = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Output burst: load on a line end, shift out one byte per request.
    always_comb begin
        burst_count_next = burst_count_reg;
        burst_data_next  = burst_data_reg;
        if (out_take) begin
            burst_count_next = burst_count_reg - 4'd1;
            burst_data_next  = {8'd0, burst_data_reg[CMD_BYTES*8-1:8]};
        end
        if (advance && line_end) begin
            burst_count_next = emit.len;
            burst_data_next  = emit.bytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_count_reg <= LEN_NONE;
        end else begin
            burst_count_reg <= burst_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        burst_data_reg <= burst_data_next;
    end

    assign m_tvalid = (burst_count_reg != LEN_NONE);
    assign m_tdata  = burst_data_reg[7:0];
    assign m_tlast  = (burst_count_reg == LEN_KEY);

endmodule

`default_nettype wire

### hdl/lcs_checker.sv
// ============================================================================
// Line command sanitizer checker
// Port-level assertions for the sanitizer unit, attached by bind.
// ============================================================================
`default_nettype none

module lcs_checker (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tready,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [7:0]    m_tdata,
    input  wire logic          m_tlast
);
    import lcs_pkg::*;

    // A stalled result request keeps its byte and its last flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result request changed while stalled");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
    else $error("result pending right after reset");

    // The input only stalls behind a result that is still being delivered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

    // Bytes before the end of a burst are command characters: A, P or a digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |->
            (m_tdata == CHR_A) || (m_tdata == CHR_P) ||
            (m_tdata >= CHR_ZERO && m_tdata <= CHR_NINE))
    else $error("unexpected byte inside a command burst");

endmodule

bind line_command_sanitizer_unit lcs_checker u_lcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/line_command_sanitizer_unit_tb.sv
// ============================================================================
// Line command sanitizer unit testbench
// Streams received bytes into the unit and predicts the cleaned command bytes
// each line end should produce. Directed lines cover full commands, keys,
// blanks and empty lines. Random lines, mostly well-formed commands and keys
// with noise mixed in, follow. Every result is checked in order against the
// prediction while the sender and the receiver both idle at random.
// ============================================================================

module line_command_sanitizer_unit_tb;

    import lcs_pkg::*;

    // Position of the command matcher within the current line.
    typedef enum logic [2:0] {
        SEEK_A,
        ANGLE,
        SEEK_P,
        POWER,
        MATCHED
    } match_phase_t;

    // One byte the unit should send downstream.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } cmd_byte_t;

    localparam string KEY_CHARS = "FBLRWXYZUSD";

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Predicted line state.
    match_phase_t phase;
    logic [1:0]   digit_cnt;
    logic [3:0]   angle_dig [3];
    logic [3:0]   power_dig [2];
    logic [1:0]   vis_count;
    logic [7:0]   first_vis;

    cmd_byte_t expected_bytes [$];
    int        errors = 0;
    int        bytes_sent = 0;
    int        burst_left = 0;
    int        rx_mode = 0;
    int        rx_left = 0;
    int        rx_tick = 0;

    line_command_sanitizer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // True for characters that may stand alone as a key.
    function automatic logic is_key_char(input logic [7:0] c);
        for (int i = 0; i < KEY_CHARS.len(); i++) begin
            if (c == KEY_CHARS[i]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function void clear_line();
        phase = SEEK_A;
        digit_cnt = 2'd0;
        angle_dig = '{4'd0, 4'd0, 4'd0};
        power_dig = '{4'd0, 4'd0};
        vis_count = 2'd0;
        first_vis = 8'h00;
    endfunction

    function void push_cmd_byte(input logic [7:0] data, input logic last);
        cmd_byte_t e;
        e.data = data;
        e.last = last;
        expected_bytes = {expected_bytes, e};
    endfunction

    // Advance the predicted line state by one accepted byte.
    function void track_byte(input logic [7:0] rx);
        logic [7:0] c;
        logic       is_digit;

        // A line end flushes the line's command or key, then starts afresh.
        if (rx == CHR_LF || rx == CHR_CR) begin
            if (phase == MATCHED) begin
                push_cmd_byte(CHR_A, 1'b0);
                for (int i = 0; i < 3; i++) begin
                    push_cmd_byte(CHR_ZERO + angle_dig[i], 1'b0);
                end
                push_cmd_byte(CHR_P, 1'b0);
                for (int i = 0; i < 2; i++) begin
                    push_cmd_byte(CHR_ZERO + power_dig[i], 1'b0);
                end
                push_cmd_byte(CHR_LF, 1'b1);
            end else if (vis_count == 2'd1 && is_key_char(first_vis)) begin
                push_cmd_byte(first_vis, 1'b1);
            end
            clear_line();
            return;
        end

        // Non-printable bytes act as blanks; lower case folds to upper case.
        c = rx;
        if (c < CHR_SPACE || c > CHR_TILDE) begin
            c = CHR_SPACE;
        end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
            c = c - CASE_OFFSET;
        end

        if (c != CHR_SPACE) begin
            if (vis_count == 2'd0) begin
                first_vis = c;
            end
            if (vis_count < 2'd2) begin
                vis_count++;
            end
        end

        is_digit = (c >= CHR_ZERO && c <= CHR_NINE);
        case (phase)
            SEEK_A: begin
                if (c == CHR_A) begin
                    phase = ANGLE;
                    digit_cnt = 2'd0;
                end
            end
            ANGLE: begin
                if (is_digit) begin
                    angle_dig[digit_cnt] = c[3:0];
                    if (digit_cnt == 2'd2) begin
                        phase = SEEK_P;
                        digit_cnt = 2'd0;
                    end else begin
                        digit_cnt++;
                    end
                end
            end
            SEEK_P: begin
                if (c == CHR_P) begin
                    phase = POWER;
                    digit_cnt = 2'd0;
                end
            end
            POWER: begin
                if (is_digit) begin
                    power_dig[digit_cnt] = c[3:0];
                    if (digit_cnt == 2'd1) begin
                        phase = MATCHED;
                        digit_cnt = 2'd0;
                    end else begin
                        digit_cnt++;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Send one byte as a request, idling between bursts of random length.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // A byte that counts as a blank: space or anything non-printable.
    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CHR_SPACE;
            1: return 8'($urandom_range(8'h00, 8'h09));
            2: return ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h0E, 8'h1F)) :
                                                    8'($urandom_range(8'h0B, 8'h0C));
            default: return 8'($urandom_range(8'h7F, 8'hFF));
        endcase
    endfunction

    // Filler the matcher skips: blanks, letters other than A and P, punctuation.
    function automatic logic [7:0] pick_filler();
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0: return pick_blank();
            1: begin
                c = 8'($urandom_range(8'h42, 8'h4F));
                return ($urandom_range(0, 1) == 1) ? (c | CASE_OFFSET) : c;
            end
            default: return 8'($urandom_range(8'h21, 8'h2F));
        endcase
    endfunction

    function automatic logic [7:0] pick_case(input logic [7:0] c);
        return ($urandom_range(0, 1) == 1) ? (c | CASE_OFFSET) : c;
    endfunction

    task automatic send_fillers(input int max_count, input logic blanks_only);
        int n;
        n = $urandom_range(0, max_count);
        for (int i = 0; i < n; i++) begin
            send_byte(blanks_only ? pick_blank() : pick_filler());
        end
    endtask

    // One random line: full or cut-short commands, keys, noise and empty lines.
    task automatic send_random_line();
        int         kind;
        int         tokens;
        logic [7:0] k;
        kind = $urandom_range(0, 9);
        if (kind <= 4 || kind == 7) begin
            tokens = (kind == 7) ? $urandom_range(0, 6) : 7;
            send_fillers(3, 1'b0);
            for (int t = 0; t < tokens; t++) begin
                if (t == 0) begin
                    send_byte(pick_case(CHR_A));
                end else if (t == 4) begin
                    send_byte(pick_case(CHR_P));
                end else begin
                    send_byte(8'($urandom_range(CHR_ZERO, CHR_NINE)));
                end
                send_fillers(2, 1'b0);
            end
            if (tokens == 7 && $urandom_range(0, 2) == 0) begin
                // Anything after a finished match is ignored by the matcher.
                send_byte(8'($urandom_range(8'h21, 8'h7E)));
                send_fillers(2, 1'b0);
            end
        end else if (kind <= 6) begin
            send_fillers(3, 1'b1);
            if ($urandom_range(0, 4) == 0) begin
                k = 8'($urandom_range(8'h21, 8'h7E));
            end else begin
                k = pick_case(KEY_CHARS[$urandom_range(0, KEY_CHARS.len() - 1)]);
            end
            send_byte(k);
            send_fillers(3, 1'b1);
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 1) == 1) begin
            // Two keys on one line do not form a key.
            send_byte(KEY_CHARS[$urandom_range(0, KEY_CHARS.len() - 1)]);
            send_fillers(2, 1'b1);
            send_byte(KEY_CHARS[$urandom_range(0, KEY_CHARS.len() - 1)]);
        end
        send_byte(($urandom_range(0, 1) == 1) ? CHR_LF : CHR_CR);
    endtask

    // Full commands: one with a lower-case A, one with skipped filler and trailing text.
    task automatic test_command_lines();
        send_text("a123P45\n");
        send_text("A9x87P0 6Z\r");
    endtask

    // Keys, blanks around a key, a non-key letter and an empty line.
    task automatic test_key_lines();
        send_text("f\r");
        send_byte(8'h00);
        send_byte("D");
        send_byte(8'hFF);
        send_byte(CHR_LF);
        send_text("Q\n");
        send_byte(CHR_LF);
    endtask

    task automatic test_random_lines();
        while (bytes_sent < 130) begin
            send_random_line();
        end
    endtask

    // Receiver: stalls on changing patterns and checks each accepted byte.
    always @(posedge aclk) begin
        cmd_byte_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    e = expected_bytes.pop_front();
                    if (m_tdata !== e.data) begin
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, e.data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                                 $time, e.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(4, 40);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= (rx_tick % 5 == 0);
            endcase
        end
    end

    initial begin
        clear_line();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_command_lines();
        test_key_lines();
        test_random_lines();
        s_tvalid <= 1'b0;

        // Drain, then keep watching for stray bytes.
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hdl/lcs_pkg.sv
hdl/lcs_line_tracker.sv
hdl/line_command_sanitizer_unit.sv
hdl/lcs_checker.sv
tb/line_command_sanitizer_unit_tb.sv
